// ===== rtl/hbrp_pkg.sv =====
`timescale 1ns / 1ps

package hbrp_pkg;

  // Accumulator width and length of the unit prefix that is skipped
  localparam int VALUE_BITS = 48;
  localparam int PREFIX_LEN = 6;

  // Result field widths
  localparam int FIRST_W = 48;
  localparam int END_W   = 49;

  localparam logic [VALUE_BITS-1:0] ACC_MAX = '1;

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NS   = 2'd1,
    ST_DECL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_CLOSED = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_SUFFIX = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_PREFIX      = 4'd0,
    PH_LEAD        = 4'd1,
    PH_START       = 4'd2,
    PH_AFTER_START = 4'd3,
    PH_AFTER_DASH  = 4'd4,
    PH_SUF_PRE     = 4'd5,
    PH_END         = 4'd6,
    PH_AFTER_END   = 4'd7,
    PH_HELD        = 4'd8
  } phase_t;

  // Phase a new header starts in
  localparam phase_t PH_INIT = (PREFIX_LEN == 0) ? PH_LEAD : PH_PREFIX;

  // acc * 10 + digit, saturating at ACC_MAX
  function automatic logic [VALUE_BITS-1:0] acc_digit(
    input logic [VALUE_BITS-1:0] acc,
    input logic [7:0]            ch
  );
    logic [VALUE_BITS+3:0] sum;
    logic [3:0]            dig;
    dig = 4'(ch - CH_DIGIT0);
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {(VALUE_BITS)'(0), dig};
    if (sum > {4'b0000, ACC_MAX}) begin
      acc_digit = ACC_MAX;
    end else begin
      acc_digit = sum[VALUE_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/hbrp_if.sv =====
`timescale 1ns / 1ps

// Header byte channel
interface hbrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// Parsed range channel
interface hbrp_out_if;
  import hbrp_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         range_kind;
  logic [FIRST_W-1:0] first_byte;
  logic [END_W-1:0]   end_excl;
  logic [END_W-1:0]   length;

  modport source (output valid, output status, output range_kind, output first_byte,
                  output end_excl, output length, input ready);
  modport sink   (input valid, input status, input range_kind, input first_byte,
                  input end_excl, input length, output ready);
endinterface

// ===== rtl/http_byte_range_parser.sv =====
`timescale 1ns / 1ps

// Parses the value of an HTTP Range header, one byte per transaction on hdr,
// ended by a zero byte. The first six bytes (the unit prefix) are skipped;
// the rest must be a single range "start-end", "start-" or "-suffix", with
// spaces allowed around the numbers. Exactly one transaction leaves on rng
// for each terminator, carrying status (ok, not satisfiable, declined), the
// form, first byte, exclusive end and length; no result appears for other
// bytes. Numbers saturate at 2^48-1. Throughput is one byte per cycle: a
// byte sits in the input register while the parse state and the x10
// accumulator update, and a terminator's result is then registered in
// the output stage. Only a stalled result with a further terminator
// behind it holds the input back.
module http_byte_range_parser (
  input logic        clk,
  input logic        rst,
  hbrp_in_if.sink    hdr,
  hbrp_out_if.source rng
);
  import hbrp_pkg::*;

  // Input register
  logic       ch_vld;
  logic [7:0] ch_r;

  // Parse state
  phase_t                phase, phase_next;
  logic [2:0]            skip_count, skip_next;
  logic [VALUE_BITS-1:0] start_acc, start_next;
  logic [VALUE_BITS-1:0] end_acc, end_next;
  logic                  suffix_flag, suffix_next;
  status_t               held_status, held_next;

  // Result register
  logic               res_vld;
  status_t            res_status;
  kind_t              res_kind;
  logic [FIRST_W-1:0] res_first;
  logic [END_W-1:0]   res_end;
  logic [END_W-1:0]   res_len;

  // Decode of the current byte
  logic    advance;
  logic    is_sp, is_nul, is_dash, is_comma, is_digit;
  logic    emit;
  status_t emit_status;
  kind_t   emit_kind;
  logic    take_start, take_end, set_suffix;
  logic [2:0] skip_inc;

  logic [VALUE_BITS:0] end_p1;
  logic [FIRST_W-1:0]  out_first;
  logic [END_W-1:0]    out_end;
  logic [END_W-1:0]    out_len;

  // only a byte that produces a result needs room in the output stage
  assign advance   = ch_vld && (!emit || !res_vld || rng.ready);
  assign hdr.ready = !ch_vld || advance;

  assign is_sp    = (ch_r == CH_SPACE);
  assign is_nul   = (ch_r == CH_NUL);
  assign is_dash  = (ch_r == CH_DASH);
  assign is_comma = (ch_r == CH_COMMA);
  assign is_digit = (ch_r >= CH_DIGIT0) && (ch_r <= CH_DIGIT9);
  assign skip_inc = skip_count + 3'd1;

  // Next phase and decisions
  always_comb begin
    phase_next  = phase;
    held_next   = held_status;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_kind   = KIND_CLOSED;
    take_start  = 1'b0;
    take_end    = 1'b0;
    set_suffix  = 1'b0;
    case (phase)
      PH_PREFIX: begin
        if (is_nul) begin
          emit        = 1'b1;
          emit_status = ST_DECL;
        end else if (skip_inc >= 3'(PREFIX_LEN)) begin
          phase_next = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (is_sp) begin
          phase_next = phase;
        end else if (is_dash) begin
          set_suffix = 1'b1;
          phase_next = PH_SUF_PRE;
        end else if (is_digit) begin
          take_start = 1'b1;
          phase_next = PH_START;
        end else if (is_nul) begin
          emit        = 1'b1;
          emit_status = ST_NS;
        end else begin
          phase_next = PH_HELD;
          held_next  = ST_NS;
        end
      end
      PH_START, PH_AFTER_START: begin
        if (phase == PH_START && is_digit) begin
          take_start = 1'b1;
        end else if (is_sp) begin
          phase_next = PH_AFTER_START;
        end else if (is_dash) begin
          phase_next = PH_AFTER_DASH;
        end else if (is_nul) begin
          emit        = 1'b1;
          emit_status = ST_NS;
        end else begin
          phase_next = PH_HELD;
          held_next  = ST_NS;
        end
      end
      PH_AFTER_DASH: begin
        if (is_sp) begin
          phase_next = phase;
        end else if (is_comma) begin
          phase_next = PH_HELD;
          held_next  = ST_DECL;
        end else if (is_nul) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_kind   = KIND_OPEN;
        end else if (is_digit) begin
          take_end   = 1'b1;
          phase_next = PH_END;
        end else begin
          phase_next = PH_HELD;
          held_next  = ST_NS;
        end
      end
      PH_SUF_PRE: begin
        if (is_sp) begin
          phase_next = phase;
        end else if (is_digit) begin
          take_end   = 1'b1;
          phase_next = PH_END;
        end else if (is_nul) begin
          emit        = 1'b1;
          emit_status = ST_NS;
        end else begin
          phase_next = PH_HELD;
          held_next  = ST_NS;
        end
      end
      PH_END, PH_AFTER_END: begin
        if (phase == PH_END && is_digit) begin
          take_end = 1'b1;
        end else if (is_sp) begin
          phase_next = PH_AFTER_END;
        end else if (is_comma) begin
          phase_next = PH_HELD;
          held_next  = ST_DECL;
        end else if (is_nul) begin
          emit = 1'b1;
          if (suffix_flag) begin
            emit_status = ST_OK;
            emit_kind   = KIND_SUFFIX;
          end else if (start_acc > end_acc) begin
            emit_status = ST_NS;
          end else begin
            emit_status = ST_OK;
            emit_kind   = KIND_CLOSED;
          end
        end else begin
          phase_next = PH_HELD;
          held_next  = ST_NS;
        end
      end
      PH_HELD: begin
        if (is_nul) begin
          emit        = 1'b1;
          emit_status = held_status;
        end
      end
      default: begin
        phase_next = PH_INIT;
      end
    endcase
    // a terminator always starts the next header
    if (emit) begin
      phase_next = PH_INIT;
      held_next  = ST_OK;
    end
  end

  // Accumulators and result fields
  always_comb begin
    skip_next   = skip_count;
    start_next  = start_acc;
    end_next    = end_acc;
    suffix_next = suffix_flag || set_suffix;
    if (phase == PH_PREFIX && !is_nul) begin
      skip_next = skip_inc;
    end
    if (take_start) begin
      start_next = acc_digit(start_acc, ch_r);
    end
    if (take_end) begin
      end_next = acc_digit(end_acc, ch_r);
    end
    if (emit) begin
      skip_next   = '0;
      start_next  = '0;
      end_next    = '0;
      suffix_next = 1'b0;
    end

    end_p1    = {1'b0, end_acc} + (VALUE_BITS+1)'(1);
    out_first = '0;
    out_end   = '0;
    out_len   = '0;
    if (emit_status == ST_OK) begin
      case (emit_kind)
        KIND_CLOSED: begin
          out_first = FIRST_W'(start_acc);
          out_end   = END_W'(end_p1);
          out_len   = END_W'(end_p1 - {1'b0, start_acc});
        end
        KIND_OPEN: begin
          out_first = FIRST_W'(start_acc);
        end
        KIND_SUFFIX: begin
          out_len = END_W'(end_acc);
        end
        default: begin
          out_first = '0;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld <= 1'b0;
    end else if (hdr.ready) begin
      ch_vld <= hdr.valid;
    end
    if (hdr.ready) begin
      ch_r <= hdr.ch;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_INIT;
      skip_count  <= '0;
      start_acc   <= '0;
      end_acc     <= '0;
      suffix_flag <= 1'b0;
      held_status <= ST_OK;
    end else if (advance) begin
      phase       <= phase_next;
      skip_count  <= skip_next;
      start_acc   <= start_next;
      end_acc     <= end_next;
      suffix_flag <= suffix_next;
      held_status <= held_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance && emit) begin
      res_vld <= 1'b1;
    end else if (rng.ready) begin
      res_vld <= 1'b0;
    end
    if (advance && emit) begin
      res_status <= emit_status;
      res_kind   <= (emit_status == ST_OK) ? emit_kind : KIND_CLOSED;
      res_first  <= out_first;
      res_end    <= out_end;
      res_len    <= out_len;
    end
  end

  assign rng.valid      = res_vld;
  assign rng.status     = res_status;
  assign rng.range_kind = res_kind;
  assign rng.first_byte = res_first;
  assign rng.end_excl   = res_end;
  assign rng.length     = res_len;

  // A terminator taken by the parse stage always produces a result
  a_term_result: assert property (@(posedge clk) disable iff (rst)
    (advance && is_nul) |=> rng.valid)
    else $error("terminator did not produce a result");

  // Only a terminator produces a result
  a_emit_only_nul: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |-> is_nul)
    else $error("result produced for a non-terminator byte");

  // Failed ranges carry no offsets
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rng.valid && rng.status != ST_OK) |->
      (rng.first_byte == '0 && rng.end_excl == '0 && rng.length == '0))
    else $error("non-ok result carries range fields");

  // Closed ranges are consistent
  a_closed_sum: assert property (@(posedge clk) disable iff (rst)
    (rng.valid && rng.status == ST_OK && rng.range_kind == KIND_CLOSED) |->
      (rng.end_excl == ({1'b0, rng.first_byte} + rng.length)))
    else $error("closed range end does not match first plus length");

endmodule

// ===== sim/tb_http_byte_range_parser.sv =====
`timescale 1ns / 1ps

module tb_http_byte_range_parser;
  import hbrp_pkg::*;

  localparam int DIR_N        = 24;
  localparam int RANDOM_BYTES = 1630;
  localparam int IDLE_PCT     = 29;

  // One parsed range as it leaves the block
  typedef struct packed {
    status_t            status;
    kind_t              range_kind;
    logic [FIRST_W-1:0] first_byte;
    logic [END_W-1:0]   end_excl;
    logic [END_W-1:0]   length;
  } range_t;

  logic clk;
  logic rst;

  hbrp_in_if  hdr_if ();
  hbrp_out_if rng_if ();

  http_byte_range_parser DUT (
    .clk (clk),
    .rst (rst),
    .hdr (hdr_if),
    .rng (rng_if)
  );

  // Parse state of the predictor
  phase_t                ph;
  logic [2:0]            skip_cnt;
  logic [VALUE_BITS-1:0] start_val;
  logic [VALUE_BITS-1:0] end_val;
  logic                  suffix_seen;
  status_t               held_st;

  range_t     expected_ranges [$];
  logic [7:0] hdr_bytes [$];
  int         errors;
  int         ranges_seen;
  int         bytes_sent;
  bit         idle_on;
  bit         use_typed;
  range_t     typed_want;

  // Directed headers; the terminator is added when sent
  string  dir_text  [DIR_N];
  bit     dir_typed [DIR_N];
  range_t dir_want  [DIR_N];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_http_byte_range_parser: FAIL");
    $finish;
  end

  function automatic range_t make_range(status_t st, kind_t kind, logic [FIRST_W-1:0] fb,
                                        logic [END_W-1:0] ex, logic [END_W-1:0] len);
    range_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.range_kind = kind;
      r.first_byte = fb;
      r.end_excl   = ex;
      r.length     = len;
    end
    return r;
  endfunction

  // acc * 10 + digit, pinned at the all-ones value on overflow
  function automatic logic [VALUE_BITS-1:0] add_digit(logic [VALUE_BITS-1:0] acc,
                                                      logic [7:0] c);
    longint unsigned w;
    w = longint'(acc) * 10 + longint'(c - CH_DIGIT0);
    if (w > longint'(ACC_MAX)) return ACC_MAX;
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic void clear_parse();
    ph          = PH_INIT;
    skip_cnt    = '0;
    start_val   = '0;
    end_val     = '0;
    suffix_seen = 1'b0;
    held_st     = ST_OK;
  endfunction

  function automatic void hold_status(status_t st);
    held_st = st;
    ph      = PH_HELD;
  endfunction

  // Advance the parse by one header byte; done marks a terminator
  task automatic predict_range(input logic [7:0] c, output bit done, output range_t r);
    bit sp;
    bit dig;
    bit nul;
    sp   = (c == CH_SPACE);
    dig  = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
    nul  = (c == CH_NUL);
    done = 1'b0;
    r    = '0;
    case (ph)
      PH_PREFIX: begin
        if (nul) begin
          r = make_range(ST_DECL, KIND_CLOSED, '0, '0, '0);
          done = 1'b1;
        end else begin
          skip_cnt = skip_cnt + 3'd1;
          if (skip_cnt >= PREFIX_LEN) ph = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (sp) begin
        end else if (c == CH_DASH) begin
          suffix_seen = 1'b1;
          ph = PH_SUF_PRE;
        end else if (dig) begin
          start_val = add_digit(start_val, c);
          ph = PH_START;
        end else if (nul) begin
          r = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
          done = 1'b1;
        end else begin
          hold_status(ST_NS);
        end
      end
      PH_START, PH_AFTER_START: begin
        if (ph == PH_START && dig) begin
          start_val = add_digit(start_val, c);
        end else if (sp) begin
          ph = PH_AFTER_START;
        end else if (c == CH_DASH) begin
          ph = PH_AFTER_DASH;
        end else if (nul) begin
          r = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
          done = 1'b1;
        end else begin
          hold_status(ST_NS);
        end
      end
      PH_AFTER_DASH: begin
        if (sp) begin
        end else if (c == CH_COMMA) begin
          hold_status(ST_DECL);
        end else if (nul) begin
          r = make_range(ST_OK, KIND_OPEN, start_val, '0, '0);
          done = 1'b1;
        end else if (dig) begin
          end_val = add_digit(end_val, c);
          ph = PH_END;
        end else begin
          hold_status(ST_NS);
        end
      end
      PH_SUF_PRE: begin
        if (sp) begin
        end else if (dig) begin
          end_val = add_digit(end_val, c);
          ph = PH_END;
        end else if (nul) begin
          r = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
          done = 1'b1;
        end else begin
          hold_status(ST_NS);
        end
      end
      PH_END, PH_AFTER_END: begin
        if (ph == PH_END && dig) begin
          end_val = add_digit(end_val, c);
        end else if (sp) begin
          ph = PH_AFTER_END;
        end else if (c == CH_COMMA) begin
          hold_status(ST_DECL);
        end else if (nul) begin
          done = 1'b1;
          if (suffix_seen) begin
            r = make_range(ST_OK, KIND_SUFFIX, '0, '0, {1'b0, end_val});
          end else if (start_val > end_val) begin
            r = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
          end else begin
            r = make_range(ST_OK, KIND_CLOSED, start_val, {1'b0, end_val} + 49'd1,
                           {1'b0, end_val} + 49'd1 - {1'b0, start_val});
          end
        end else begin
          hold_status(ST_NS);
        end
      end
      default: begin
        if (nul) begin
          r = make_range(held_st, KIND_CLOSED, '0, '0, '0);
          done = 1'b1;
        end
      end
    endcase
    if (done) clear_parse();
  endtask

  // Offer one byte, wait for the transaction, then predict
  task automatic send_byte(input logic [7:0] c);
    bit     done;
    range_t r;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      hdr_if.valid <= 1'b0;
      @(posedge clk);
    end
    hdr_if.valid <= 1'b1;
    hdr_if.ch    <= c;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    bytes_sent++;
    predict_range(c, done, r);
    if (done) expected_ranges.push_back(use_typed ? typed_want : r);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endtask

  task automatic push_spaces();
    int n;
    n = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) hdr_bytes.push_back(CH_SPACE);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return VALUE_BITS'($urandom_range(9));
      1:       return VALUE_BITS'($urandom_range(999));
      2:       return VALUE_BITS'($urandom_range(99999));
      3:       return VALUE_BITS'($urandom);
      4:       return w[VALUE_BITS-1:0];
      default: return ACC_MAX - VALUE_BITS'($urandom_range(3));
    endcase
  endfunction

  // Decimal text of v, sometimes zero-padded, sometimes an overlong digit run
  task automatic push_number(input logic [VALUE_BITS-1:0] v);
    logic [7:0]      digits [$];
    longint unsigned x;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(15, 22)) hdr_bytes.push_back(CH_DIGIT0 + 8'($urandom_range(9)));
    end else begin
      if ($urandom_range(9) == 0) hdr_bytes.push_back(CH_DIGIT0);
      x = longint'(v);
      do begin
        digits.push_front(CH_DIGIT0 + 8'(x % 10));
        x = x / 10;
      end while (x != 0);
      foreach (digits[i]) hdr_bytes.push_back(digits[i]);
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_DASH;
      2:       return CH_COMMA;
      3:       return CH_DIGIT0 + 8'($urandom_range(9));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Build one random header, terminator included
  task automatic build_header();
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
    logic [VALUE_BITS-1:0] t;
    int                    pick;
    hdr_bytes.delete();
    pick = $urandom_range(9);
    if (pick == 0) begin
      repeat ($urandom_range(0, 14)) hdr_bytes.push_back(noise_byte());
    end else begin
      if ($urandom_range(3) == 0) begin
        repeat (PREFIX_LEN) hdr_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
        push_text("bytes=");
      end
      if (pick == 1) begin
        repeat ($urandom_range(0, 10)) hdr_bytes.push_back(noise_byte());
      end else begin
        push_spaces();
        case ($urandom_range(2))
          0: begin
            a = pick_value();
            b = pick_value();
            if (a > b && $urandom_range(4) != 0) begin
              t = a;
              a = b;
              b = t;
            end
            push_number(a);
            push_spaces();
            hdr_bytes.push_back(CH_DASH);
            push_spaces();
            push_number(b);
          end
          1: begin
            push_number(pick_value());
            push_spaces();
            hdr_bytes.push_back(CH_DASH);
          end
          default: begin
            hdr_bytes.push_back(CH_DASH);
            push_spaces();
            push_number(pick_value());
          end
        endcase
        push_spaces();
        case ($urandom_range(9))
          0: begin
            hdr_bytes.push_back(CH_COMMA);
            push_text("5-9");
          end
          1: hdr_bytes.push_back(noise_byte());
          default: begin
          end
        endcase
      end
    end
    hdr_bytes.push_back(CH_NUL);
  endtask

  task automatic drain();
    hdr_if.valid <= 1'b0;
    wait (expected_ranges.size() == 0);
    @(posedge clk);
  endtask

  // Result side: check each transaction, stall at random and once for long
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    rng_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rng_if.valid && rng_if.ready) begin
        if (expected_ranges.size() == 0) begin
          $error("unexpected range result: status %0d", rng_if.status);
          errors++;
        end else begin
          range_t w;
          w = expected_ranges.pop_front();
          if (rng_if.status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, rng_if.status);
            errors++;
          end
          if (rng_if.range_kind !== w.range_kind) begin
            $error("range_kind: expected %0d, actual %0d", w.range_kind, rng_if.range_kind);
            errors++;
          end
          if (rng_if.first_byte !== w.first_byte) begin
            $error("first_byte: expected %0d, actual %0d", w.first_byte, rng_if.first_byte);
            errors++;
          end
          if (rng_if.end_excl !== w.end_excl) begin
            $error("end_excl: expected %0d, actual %0d", w.end_excl, rng_if.end_excl);
            errors++;
          end
          if (rng_if.length !== w.length) begin
            $error("length: expected %0d, actual %0d", w.length, rng_if.length);
            errors++;
          end
        end
        ranges_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rng_if.ready <= 1'b0;
      end else if (!held_once && ranges_seen == 40) begin
        held_once = 1'b1;
        hold_left = 400;
        rng_if.ready <= 1'b0;
      end else begin
        rng_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus
  initial begin
    string s;
    int    rnd_start;
    int    hdr_count;
    errors      = 0;
    ranges_seen = 0;
    bytes_sent  = 0;
    idle_on     = 1'b1;
    use_typed   = 1'b0;
    typed_want  = '0;
    clear_parse();
    rst          <= 1'b1;
    hdr_if.valid <= 1'b0;
    hdr_if.ch    <= CH_NUL;

    foreach (dir_typed[i]) begin
      dir_typed[i] = 1'b0;
      dir_want[i]  = '0;
    end
    // Terminator inside the prefix, and an empty header
    dir_text[0]  = "byt";
    dir_typed[0] = 1'b1;
    dir_want[0]  = make_range(ST_DECL, KIND_CLOSED, '0, '0, '0);
    dir_text[1]  = "";
    dir_typed[1] = 1'b1;
    dir_want[1]  = make_range(ST_DECL, KIND_CLOSED, '0, '0, '0);
    // Nothing after the prefix
    dir_text[2]  = "bytes=";
    dir_typed[2] = 1'b1;
    dir_want[2]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[3]  = "bytes=0-0";
    dir_text[4]  = "bytes=100-199";
    dir_text[5]  = "bytes= 500 - 999 ";
    dir_text[6]  = "bytes=9500-";
    dir_text[7]  = "bytes=-500";
    // Largest closed range and saturated numbers
    dir_text[8]  = "bytes=0-281474976710655";
    dir_typed[8] = 1'b1;
    dir_want[8]  = make_range(ST_OK, KIND_CLOSED, '0, 49'h1_0000_0000_0000,
                              49'h1_0000_0000_0000);
    dir_text[9]  = "bytes=99999999999999999999-";
    dir_typed[9] = 1'b1;
    dir_want[9]  = make_range(ST_OK, KIND_OPEN, ACC_MAX, '0, '0);
    dir_text[10]  = "bytes=-99999999999999999999";
    dir_typed[10] = 1'b1;
    dir_want[10]  = make_range(ST_OK, KIND_SUFFIX, '0, '0, {1'b0, ACC_MAX});
    // Start above end
    dir_text[11]  = "bytes=5-3";
    dir_typed[11] = 1'b1;
    dir_want[11]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    // Multi-range, after a closed and after an open range
    dir_text[12]  = "bytes=0-5,7-9";
    dir_typed[12] = 1'b1;
    dir_want[12]  = make_range(ST_DECL, KIND_CLOSED, '0, '0, '0);
    dir_text[13]  = "bytes=1-,";
    dir_typed[13] = 1'b1;
    dir_want[13]  = make_range(ST_DECL, KIND_CLOSED, '0, '0, '0);
    // Stray bytes
    dir_text[14]  = "bytes=x";
    dir_typed[14] = 1'b1;
    dir_want[14]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[15]  = "bytes=1 2-3";
    dir_typed[15] = 1'b1;
    dir_want[15]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[16]  = "bytes=-";
    dir_typed[16] = 1'b1;
    dir_want[16]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[17]  = "bytes=-5 7";
    dir_typed[17] = 1'b1;
    dir_want[17]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[18]  = "bytes=1-2 3";
    dir_typed[18] = 1'b1;
    dir_want[18]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[19]  = "bytes=7 ";
    dir_typed[19] = 1'b1;
    dir_want[19]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[20]  = "bytes=- 12 ";
    dir_text[21]  = "bytes=\377";
    dir_typed[21] = 1'b1;
    dir_want[21]  = make_range(ST_NS, KIND_CLOSED, '0, '0, '0);
    dir_text[22]  = "\200\377\200\377\200\3770-0";
    dir_text[23]  = "bytes=281474976710654-281474976710655";

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed headers
    for (int i = 0; i < DIR_N; i++) begin
      s          = dir_text[i];
      use_typed  = dir_typed[i];
      typed_want = dir_want[i];
      for (int j = 0; j < s.len(); j++) send_byte(s[j]);
      send_byte(CH_NUL);
    end
    use_typed = 1'b0;
    drain();

    // Random headers, with a stretch without idling and a drain midway
    rnd_start = bytes_sent;
    hdr_count = 0;
    while (bytes_sent - rnd_start < RANDOM_BYTES) begin
      idle_on = !((bytes_sent - rnd_start) >= 700 && (bytes_sent - rnd_start) < 1100);
      build_header();
      foreach (hdr_bytes[i]) send_byte(hdr_bytes[i]);
      hdr_count++;
      if (hdr_count == 100) drain();
    end
    idle_on = 1'b1;
    hdr_if.valid <= 1'b0;

    wait (expected_ranges.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_http_byte_range_parser: PASS");
    end else begin
      $display("tb_http_byte_range_parser: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hbrp_pkg.sv
rtl/hbrp_if.sv
rtl/http_byte_range_parser.sv
sim/tb_http_byte_range_parser.sv
